### hw/rtl/rti_pkg.sv
// Shared types, widths and breakpoint tables for the reflectivity table interpolator.
package rti_pkg;

    localparam int E_W           = 20;
    localparam int R_W           = 24;
    localparam int STORED_POINTS = 36;
    localparam int K_W           = $clog2(STORED_POINTS + 1);
    localparam int SEG_W         = $clog2(STORED_POINTS - 1);
    localparam int DEN_W         = 14;
    localparam int DR_W          = 13;
    localparam int NUM_W         = 28;
    localparam int RECIP_SHIFT   = 32;
    localparam int RECIP_W       = 22;
    localparam int PROD_W        = NUM_W + RECIP_W;
    localparam int Q_W           = PROD_W - RECIP_SHIFT;
    localparam int QD_W          = Q_W + DEN_W;
    localparam int SCALE_W       = 2 * R_W;

    localparam logic [R_W-1:0]     LOSS_RESET = 24'd16763794;
    localparam logic [SCALE_W-1:0] SCALE_HALF = SCALE_W'(1) << (R_W - 1);

    localparam logic [63:0] HC_Q16   = 64'd81254276;
    localparam logic [63:0] RF_SCALE = 64'd16777216;
    localparam logic [63:0] RF_HALF  = 64'd500000000;
    localparam logic [63:0] RF_DIV   = 64'd1000000000;

    localparam logic [E_W-1:0] BP_ENERGY [STORED_POINTS] = '{
        E_W'((HC_Q16 + 64'd325) / 64'd650), E_W'((HC_Q16 + 64'd320) / 64'd640),
        E_W'((HC_Q16 + 64'd315) / 64'd630), E_W'((HC_Q16 + 64'd310) / 64'd620),
        E_W'((HC_Q16 + 64'd305) / 64'd610), E_W'((HC_Q16 + 64'd300) / 64'd600),
        E_W'((HC_Q16 + 64'd295) / 64'd590), E_W'((HC_Q16 + 64'd290) / 64'd580),
        E_W'((HC_Q16 + 64'd285) / 64'd570), E_W'((HC_Q16 + 64'd280) / 64'd560),
        E_W'((HC_Q16 + 64'd275) / 64'd550), E_W'((HC_Q16 + 64'd270) / 64'd540),
        E_W'((HC_Q16 + 64'd265) / 64'd530), E_W'((HC_Q16 + 64'd260) / 64'd520),
        E_W'((HC_Q16 + 64'd255) / 64'd510), E_W'((HC_Q16 + 64'd250) / 64'd500),
        E_W'((HC_Q16 + 64'd245) / 64'd490), E_W'((HC_Q16 + 64'd240) / 64'd480),
        E_W'((HC_Q16 + 64'd235) / 64'd470), E_W'((HC_Q16 + 64'd230) / 64'd460),
        E_W'((HC_Q16 + 64'd225) / 64'd450), E_W'((HC_Q16 + 64'd220) / 64'd440),
        E_W'((HC_Q16 + 64'd215) / 64'd430), E_W'((HC_Q16 + 64'd210) / 64'd420),
        E_W'((HC_Q16 + 64'd205) / 64'd410), E_W'((HC_Q16 + 64'd200) / 64'd400),
        E_W'((HC_Q16 + 64'd195) / 64'd390), E_W'((HC_Q16 + 64'd190) / 64'd380),
        E_W'((HC_Q16 + 64'd185) / 64'd370), E_W'((HC_Q16 + 64'd180) / 64'd360),
        E_W'((HC_Q16 + 64'd175) / 64'd350), E_W'((HC_Q16 + 64'd170) / 64'd340),
        E_W'((HC_Q16 + 64'd165) / 64'd330), E_W'((HC_Q16 + 64'd160) / 64'd320),
        E_W'((HC_Q16 + 64'd155) / 64'd310), E_W'((HC_Q16 + 64'd150) / 64'd300)
    };

    localparam logic [R_W-1:0] REFL_Q24 [STORED_POINTS] = '{
        R_W'((64'd999895281 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999891334 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999885743 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999878696 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999870426 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999861200 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999851309 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999841055 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999830735 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999820635 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999811012 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999802084 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999794018 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999786917 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999780807 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999775625 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999771209 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999767282 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999763441 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999759146 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999753706 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999746266 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999735798 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999721084 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999700708 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999673040 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999636227 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999588178 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999526552 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999448747 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999351887 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999232808 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd999088050 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd998913839 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd998706078 * RF_SCALE + RF_HALF) / RF_DIV),
        R_W'((64'd998460335 * RF_SCALE + RF_HALF) / RF_DIV)
    };

    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
        logic [RECIP_W-1:0] recip;
        logic [R_W-1:0]     r_lo;
        logic               neg;
        logic               clamped;
    } t_op;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic [R_W-1:0] r_lo;
        logic           neg;
        logic           clamped;
    } t_quo;

endpackage

### hw/rtl/rti_segment.sv
// Breakpoint search and per-segment operand fetch, two pipeline stages.
module rti_segment #(
    parameter int TABLE_POINTS = 36
) (
    input  logic                    i_clk,
    input  logic [1:0]              i_ld,
    input  logic [rti_pkg::E_W-1:0] i_energy,
    output rti_pkg::t_op            o_op
);
    import rti_pkg::*;

    localparam int USED = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                          ((TABLE_POINTS < 1) ? 1 : TABLE_POINTS);
    localparam logic [K_W-1:0] USED_K = K_W'(USED);
    localparam int NSEG = STORED_POINTS - 1;

    logic [DEN_W-1:0]   seg_den   [NSEG];
    logic [DR_W-1:0]    seg_dr    [NSEG];
    logic [RECIP_W-1:0] seg_recip [NSEG];
    logic               seg_neg   [NSEG];

    for (genvar g = 0; g < NSEG; g++) begin : g_seg
        localparam logic [63:0] LO    = 64'(BP_ENERGY[g]);
        localparam logic [63:0] HI    = 64'(BP_ENERGY[g+1]);
        localparam logic [63:0] DEN   = HI - LO;
        localparam logic [63:0] RLO   = 64'(REFL_Q24[g]);
        localparam logic [63:0] RHI   = 64'(REFL_Q24[g+1]);
        localparam bit          NEG   = (RHI < RLO);
        localparam logic [63:0] DR    = NEG ? (RLO - RHI) : (RHI - RLO);
        localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / DEN;
        assign seg_den[g]   = DEN_W'(DEN);
        assign seg_dr[g]    = DR_W'(DR);
        assign seg_recip[g] = RECIP_W'(RECIP);
        assign seg_neg[g]   = NEG;
    end

    logic [STORED_POINTS-1:0] le;
    logic [K_W-1:0]           n_k;
    logic [K_W-1:0]           r_k;
    logic [E_W-1:0]           r_energy;
    logic                     n_clamp;
    logic [SEG_W-1:0]         n_seg;
    logic [DEN_W-1:0]         n_dx;
    t_op                      n_op;
    t_op                      r_op;

    always_comb begin
        for (int i = 0; i < STORED_POINTS; i++) begin
            le[i] = (i < USED) && (BP_ENERGY[i] <= i_energy);
        end
        n_k = K_W'($countones(le));
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_k      <= n_k;
            r_energy <= i_energy;
        end
    end

    always_comb begin
        n_clamp = (r_k == '0) || (r_k >= USED_K);
        n_seg   = n_clamp ? '0 : SEG_W'(r_k - K_W'(1));
        n_dx    = DEN_W'(r_energy - BP_ENERGY[n_seg]);
        if (n_clamp) begin
            n_op.num     = '0;
            n_op.den     = DEN_W'(1);
            n_op.recip   = '0;
            n_op.r_lo    = (r_k == '0) ? REFL_Q24[0] : REFL_Q24[USED-1];
            n_op.neg     = 1'b0;
            n_op.clamped = 1'b1;
        end else begin
            n_op.num     = NUM_W'(n_dx) * NUM_W'(seg_dr[n_seg])
                         + NUM_W'(seg_den[n_seg] >> 1);
            n_op.den     = seg_den[n_seg];
            n_op.recip   = seg_recip[n_seg];
            n_op.r_lo    = REFL_Q24[n_seg];
            n_op.neg     = seg_neg[n_seg];
            n_op.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_op <= n_op;
        end
    end

    assign o_op = r_op;

endmodule

### hw/rtl/rti_divide.sv
// Rounded quotient by reciprocal multiply with one correction step, three stages.
module rti_divide (
    input  logic          i_clk,
    input  logic [2:0]    i_ld,
    input  rti_pkg::t_op  i_op,
    output rti_pkg::t_quo o_quo
);
    import rti_pkg::*;

    logic [PROD_W-1:0] r_prod;
    t_op               r_op_a;
    logic [Q_W-1:0]    n_q0;
    logic [Q_W-1:0]    r_q0;
    logic [QD_W-1:0]   r_qd;
    t_op               r_op_b;
    logic [NUM_W-1:0]  n_rem;
    t_quo              r_quo;

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_prod <= PROD_W'(i_op.num) * PROD_W'(i_op.recip);
            r_op_a <= i_op;
        end
    end

    assign n_q0 = r_prod[PROD_W-1:RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_q0   <= n_q0;
            r_qd   <= QD_W'(n_q0) * QD_W'(r_op_a.den);
            r_op_b <= r_op_a;
        end
    end

    assign n_rem = r_op_b.num - NUM_W'(r_qd);

    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r_quo.q       <= r_q0 + Q_W'(n_rem >= NUM_W'(r_op_b.den));
            r_quo.r_lo    <= r_op_b.r_lo;
            r_quo.neg     <= r_op_b.neg;
            r_quo.clamped <= r_op_b.clamped;
        end
    end

    assign o_quo = r_quo;

endmodule

### hw/rtl/rti_scale.sv
// Reflectivity reconstruction and loss-factor scaling with rounding, two stages.
module rti_scale (
    input  logic                    i_clk,
    input  logic [1:0]              i_ld,
    input  rti_pkg::t_quo           i_quo,
    input  logic [rti_pkg::R_W-1:0] i_loss,
    output logic [rti_pkg::R_W-1:0] o_prob,
    output logic                    o_clamped
);
    import rti_pkg::*;

    logic [R_W-1:0]     n_refl;
    logic [R_W-1:0]     r_refl;
    logic               r_clamp_a;
    logic [SCALE_W-1:0] r_prod;
    logic               r_clamp_b;

    assign n_refl = i_quo.neg ? (i_quo.r_lo - R_W'(i_quo.q)) : (i_quo.r_lo + R_W'(i_quo.q));

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_refl    <= n_refl;
            r_clamp_a <= i_quo.clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_prod    <= SCALE_W'(r_refl) * SCALE_W'(i_loss) + SCALE_HALF;
            r_clamp_b <= r_clamp_a;
        end
    end

    assign o_prob    = r_prod[SCALE_W-1:R_W];
    assign o_clamped = r_clamp_b;

endmodule

### hw/rtl/reflectivity_table_interpolator.sv
// Top level of the reflectivity table interpolator pipeline.
// Usage:
// A request on the input channel carries one photon energy (unsigned Q4.16).
// It is taken at a clock edge where i_valid is high and o_stall is low. Each
// request yields exactly one result: the interpolated reflectivity scaled by
// the loss factor (unsigned Q0.24) and a flag that is set when the energy lay
// below the first or at or above the last breakpoint. The result is taken at an
// edge where o_valid is high and i_stall is low.
// The pipeline has seven register stages: search, operand fetch, reciprocal
// multiply, quotient times divisor, correction, reconstruction, scaling. While
// the receiver does not stall, a new request can enter every cycle, so
// sustained throughput is one item per cycle.
// When the receiver stalls, only stages that hold data and cannot drain stop;
// empty stages still fill, and o_stall rises once the full pipeline is blocked.
// The loss factor is written through the configuration channel, which is
// always ready; write it only while the pipeline is empty.
// Reset clears all stage valid bits and loads the loss factor with 0.9992.
module reflectivity_table_interpolator #(
    parameter int TABLE_POINTS = 36
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [rti_pkg::E_W-1:0] i_photon_energy,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [rti_pkg::R_W-1:0] o_reflect_probability,
    output logic                    o_clamped,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [rti_pkg::R_W-1:0] i_cfg_data
);
    import rti_pkg::*;

    localparam int NSTAGE = 7;

    logic [NSTAGE:0]   ld;
    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE-1:0] n_valid;
    logic [R_W-1:0]    r_loss;
    t_op               op;
    t_quo              quo;

    always_comb begin
        ld[NSTAGE] = !i_stall;
        for (int s = NSTAGE - 1; s >= 0; s--) begin
            ld[s] = !r_valid[s] || ld[s+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (ld[0]) begin
            n_valid[0] = i_valid;
        end
        for (int s = 1; s < NSTAGE; s++) begin
            if (ld[s]) begin
                n_valid[s] = r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss <= LOSS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_loss <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !ld[0];
    assign o_valid     = r_valid[NSTAGE-1];

    rti_segment #(
        .TABLE_POINTS(TABLE_POINTS)
    ) u_segment (
        .i_clk    (i_clk),
        .i_ld     (ld[1:0]),
        .i_energy (i_photon_energy),
        .o_op     (op)
    );

    rti_divide u_divide (
        .i_clk (i_clk),
        .i_ld  (ld[4:2]),
        .i_op  (op),
        .o_quo (quo)
    );

    rti_scale u_scale (
        .i_clk     (i_clk),
        .i_ld      (ld[6:5]),
        .i_quo     (quo),
        .i_loss    (r_loss),
        .o_prob    (o_reflect_probability),
        .o_clamped (o_clamped)
    );

endmodule
